// ----- hdl/wtc_pkg.sv -----
// wtc_pkg: shared types, constants and the CRC-8 step for the word triplet checker.
// No dependencies; every other file of the block imports it.
package wtc_pkg;

	// CRC-8, polynomial 0x31, MSB first, no reflection, no final xor
	localparam logic [7:0] CRC_INIT    = 8'hFF;
	localparam logic [7:0] CRC_POLY    = 8'h31;

	// framing limits
	localparam logic [3:0] MAX_WORDS   = 4'd9;
	localparam logic [3:0] WORDS_RESET = 4'd9;

	// byte positions within one three-byte word
	typedef enum logic [1:0] {
		POS_UPPER = 2'd0,
		POS_LOWER = 2'd1,
		POS_CRC   = 2'd2,
		POS_SPARE = 2'd3
	} byte_pos_t;

	// result status codes
	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_CRC_ERR = 1'b1;

	// default depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       start_of_response;
	} in_word_t;

	typedef struct packed {
		logic [15:0] data_word;
		logic [3:0]  word_index;
		logic        word_status;
		logic        last;
	} out_word_t;

	// one byte through the CRC, eight shift steps
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

	// map the register value onto the usable range 1..9
	function automatic logic [3:0] eff_words(input logic [3:0] w);
		logic [3:0] r;
		if (w == 4'd0) begin
			r = 4'd1;
		end else if (w > MAX_WORDS) begin
			r = MAX_WORDS;
		end else begin
			r = w;
		end
		return r;
	endfunction

endpackage

// ----- hdl/wtc_front.sv -----
// wtc_front: accepts received bytes, tracks word framing and the running CRC,
// and pushes one finished word per three bytes. Depends on wtc_pkg.
module wtc_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               full,
	input  wtc_pkg::in_word_t  in_data,
	input  logic               cfg_we,
	input  logic [3:0]         cfg_wdata,
	output logic               push,
	output wtc_pkg::out_word_t push_data
);
	import wtc_pkg::*;

	byte_pos_t  pos_q, pos_d;
	logic [7:0] crc_q, crc_d;
	logic [7:0] upper_q, upper_d;
	logic [7:0] lower_q, lower_d;
	logic [3:0] words_done_q, words_done_d;
	logic       halted_q, halted_d;
	logic [3:0] words_exp_q;

	logic       accept;
	byte_pos_t  pos_e;
	logic [7:0] crc_e;
	logic [3:0] words_done_e;
	logic       halted_e;
	logic       bad;
	logic       fin;
	logic [4:0] idx_next;

	assign accept = in_valid & ~full;

	// hold the word count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			words_exp_q <= WORDS_RESET;
		end else if (cfg_we) begin
			words_exp_q <= cfg_wdata;
		end
	end

	// apply the start mark, then advance framing
	always_comb begin
		pos_e        = in_data.start_of_response ? POS_UPPER : pos_q;
		crc_e        = in_data.start_of_response ? CRC_INIT : crc_q;
		words_done_e = in_data.start_of_response ? 4'd0 : words_done_q;
		halted_e     = in_data.start_of_response ? 1'b0 : halted_q;

		pos_d        = pos_e;
		crc_d        = crc_e;
		upper_d      = upper_q;
		lower_d      = lower_q;
		words_done_d = words_done_e;
		halted_d     = halted_e;
		push         = 1'b0;

		bad      = (crc_e != in_data.rx_byte);
		idx_next = {1'b0, words_done_e} + 5'd1;
		fin      = bad || (idx_next >= {1'b0, eff_words(words_exp_q)});

		push_data.data_word   = {upper_q, lower_q};
		push_data.word_index  = words_done_e;
		push_data.word_status = bad ? STATUS_CRC_ERR : STATUS_OK;
		push_data.last        = fin;

		if (accept && !halted_e) begin
			unique case (pos_e)
				POS_LOWER: begin
					lower_d = in_data.rx_byte;
					crc_d   = crc8_update(crc_e, in_data.rx_byte);
					pos_d   = POS_CRC;
				end
				POS_CRC: begin
					push         = 1'b1;
					words_done_d = idx_next[3:0];
					pos_d        = POS_UPPER;
					crc_d        = CRC_INIT;
					halted_d     = fin;
				end
				POS_UPPER, POS_SPARE: begin
					upper_d = in_data.rx_byte;
					crc_d   = crc8_update(CRC_INIT, in_data.rx_byte);
					pos_d   = POS_LOWER;
				end
				default: begin
					pos_d = POS_UPPER;
				end
			endcase
		end else if (accept) begin
			// halted: keep only what the start mark changed
			pos_d = pos_e;
		end else begin
			pos_d        = pos_q;
			crc_d        = crc_q;
			words_done_d = words_done_q;
			halted_d     = halted_q;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= POS_UPPER;
			crc_q        <= CRC_INIT;
			words_done_q <= 4'd0;
			halted_q     <= 1'b1;
		end else begin
			pos_q        <= pos_d;
			crc_q        <= crc_d;
			words_done_q <= words_done_d;
			halted_q     <= halted_d;
		end
	end

	// data bytes of the current word
	always_ff @(posedge clk) begin
		upper_q <= upper_d;
		lower_q <= lower_d;
	end

endmodule

// ----- hdl/wtc_queue.sv -----
// wtc_queue: short first-in first-out queue that holds finished words and
// drives the output channel from its head. Depends on wtc_pkg.
module wtc_queue #(
	parameter int Depth = wtc_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  wtc_pkg::out_word_t push_data,
	output logic               full,
	output logic               out_valid,
	input  logic               out_stall,
	output wtc_pkg::out_word_t out_data
);
	import wtc_pkg::*;

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr  = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

	out_word_t       mem [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            pop;

	assign full      = (count_q == DepthCnt);
	assign out_valid = (count_q != '0);
	assign out_data  = mem[rd_ptr_q];
	assign pop       = out_valid & ~out_stall;

	// store pushed words
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- hdl/word_triplet_crc8_checker.sv -----
// word_triplet_crc8_checker: top level, byte framing front and word queue back.
// Depends on wtc_pkg, wtc_front and wtc_queue.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall   | in_word_t (rx_byte, start_of_response)
//   out     | output    | out_valid/out_stall | out_word_t (data_word, word_index, ...)
//   cfg     | input     | cfg_we              | cfg_wdata (words_expected)
//
// One byte is taken every cycle unless in_stall is high; the CRC step for a byte is
// done in the cycle it is accepted. A finished word is queued as its CRC byte is taken.
// in_stall rises only when the Depth-entry word queue is full.
// Reset is asynchronous, active low; it empties the queue and halts framing.
module word_triplet_crc8_checker #(
	parameter int Depth = wtc_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  wtc_pkg::in_word_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output wtc_pkg::out_word_t out_data,
	input  logic               cfg_we,
	input  logic [3:0]         cfg_wdata
);
	import wtc_pkg::*;

	logic      push;
	logic      full;
	out_word_t push_data;

	assign in_stall = full;

	wtc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.full      (full),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.push      (push),
		.push_data (push_data)
	);

	wtc_queue #(
		.Depth (Depth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

// ----- hdl/wtc_checker.sv -----
// wtc_checker: port-level assertions for the word triplet checker, bound to the top.
// Depends on wtc_pkg and word_triplet_crc8_checker.
module wtc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input wtc_pkg::out_word_t out_data
);
	import wtc_pkg::*;

	// stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled output word changed");

	// input stalls only while words wait
	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with empty queue");

	// a CRC error always ends the response
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.word_status == STATUS_CRC_ERR |-> out_data.last)
		else $error("CRC error word not marked last");

	// index stays within nine words
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.word_index <= 4'd8)
		else $error("word index out of range");

endmodule

bind word_triplet_crc8_checker wtc_checker u_wtc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

// ----- bench/tb.sv -----
// tb: self-checking bench for word_triplet_crc8_checker, byte stream in and checked words out.
// Depends on wtc_pkg for the payload structs, the byte position enum and the CRC constants.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import wtc_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 90;
	localparam int HOLD_AFTER  = 300;
	localparam int PHASE_BYTES = 62;
	localparam int SETTLE      = 6;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	in_word_t   in_data = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	out_word_t  out_data;
	logic       cfg_we = 1'b0;
	logic [3:0] cfg_wdata = '0;

	word_triplet_crc8_checker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// bytes waiting to be sent and words the checker should produce
	in_word_t  byte_q[$];
	out_word_t due_words[$];

	// local copy of the framing state
	logic [3:0] words_reg = WORDS_RESET;
	byte_pos_t  fr_pos = POS_UPPER;
	logic [7:0] fr_crc = CRC_INIT;
	logic [7:0] fr_upper = '0;
	logic [7:0] fr_lower = '0;
	logic [3:0] fr_done = '0;
	logic       fr_halted = 1'b1;

	int  errors = 0;
	int  words_queued = 0;
	int  words_accepted = 0;
	int  words_checked = 0;
	int  crc_errs_seen = 0;
	int  finals_seen = 0;
	int  settings_used = 1;
	int  cycle_count = 0;
	int  gap_left = 0;
	int  stall_left = 0;
	int  hold_count = 0;
	bit  hold_done = 1'b0;
	bit  quiet = 1'b0;
	logic rx_hold = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// CRC-8 over one byte, polynomial 0x31, MSB first
	function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] b);
		logic [7:0] r;
		r = acc ^ b;
		repeat (8) r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
		return r;
	endfunction

	// words per response as the register value is interpreted
	function automatic int words_span(input logic [3:0] w);
		if (w == 4'd0)
			return 1;
		if (w > MAX_WORDS)
			return int'(MAX_WORDS);
		return int'(w);
	endfunction

	// advance the framing on one accepted byte, queue the word it finishes
	function automatic void frame_byte(input in_word_t w);
		out_word_t o;
		logic bad;
		if (w.start_of_response) begin
			fr_pos = POS_UPPER;
			fr_crc = CRC_INIT;
			fr_done = '0;
			fr_halted = 1'b0;
		end
		if (fr_halted)
			return;
		case (fr_pos)
			POS_LOWER: begin
				fr_lower = w.rx_byte;
				fr_crc = crc8_step(fr_crc, w.rx_byte);
				fr_pos = POS_CRC;
			end
			POS_CRC: begin
				bad = (fr_crc != w.rx_byte);
				o.data_word = {fr_upper, fr_lower};
				o.word_index = fr_done;
				o.word_status = bad ? STATUS_CRC_ERR : STATUS_OK;
				o.last = bad || (int'(fr_done) + 1 >= words_span(words_reg));
				due_words.push_back(o);
				fr_done = fr_done + 4'd1;
				fr_pos = POS_UPPER;
				fr_crc = CRC_INIT;
				if (o.last)
					fr_halted = 1'b1;
			end
			default: begin
				fr_upper = w.rx_byte;
				fr_crc = crc8_step(CRC_INIT, w.rx_byte);
				fr_pos = POS_LOWER;
			end
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= 30)
			$display("MISMATCH at cycle %0d: %s", cycle_count, msg);
	endtask

	task automatic push_byte(input logic [7:0] b, input logic sor);
		in_word_t w;
		w.rx_byte = b;
		w.start_of_response = sor;
		byte_q.push_back(w);
		words_queued++;
	endtask

	// two data bytes and their CRC, optionally corrupted
	task automatic push_triplet(input logic [7:0] hi, input logic [7:0] lo, input bit corrupt,
			input logic sor);
		logic [7:0] c;
		c = crc8_step(crc8_step(CRC_INIT, hi), lo);
		if (corrupt)
			c = c ^ 8'($urandom_range(1, 255));
		push_byte(hi, sor);
		push_byte(lo, 1'b0);
		push_byte(c, 1'b0);
	endtask

	// mostly whole responses, some cut short, some stray bytes
	task automatic fill_phase(input int target);
		int first;
		int pick;
		int n;
		first = words_queued;
		while (words_queued - first < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				n = words_span(words_reg);
				if ($urandom_range(0, 3) == 0)
					n = $urandom_range(1, n);
				for (int k = 0; k < n; k++)
					push_triplet(8'($urandom), 8'($urandom), $urandom_range(0, 11) == 0, k == 0);
			end else if (pick < 85) begin
				n = $urandom_range(0, 4);
				push_byte(8'($urandom), 1'b1);
				for (int k = 0; k < n; k++)
					push_byte(8'($urandom), 1'b0);
			end else begin
				n = $urandom_range(1, 4);
				for (int k = 0; k < n; k++)
					push_byte(8'($urandom), $urandom_range(0, 3) == 0);
			end
		end
	endtask

	// wait until every byte is taken and every word has come out
	task automatic drain;
		while (words_accepted != words_queued || due_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_words(input logic [3:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		words_reg = v;
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// drive the byte channel: hold while stalled, otherwise idle or advance
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				frame_byte(in_data);
				words_accepted++;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left == 0 && !quiet && $urandom_range(0, 5) == 0)
					gap_left = $urandom_range(1, 15);
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (byte_q.size() > 0) begin
					in_data <= byte_q.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// check each word taken from the output, then pick the next stall
	always @(posedge clk) begin
		out_word_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (due_words.size() == 0) begin
					report_mismatch($sformatf("unexpected word %h", out_data));
				end else begin
					e = due_words.pop_front();
					if (out_data.data_word !== e.data_word)
						report_mismatch($sformatf("data_word %h, want %h",
							out_data.data_word, e.data_word));
					if (out_data.word_index !== e.word_index)
						report_mismatch($sformatf("word_index %0d, want %0d",
							out_data.word_index, e.word_index));
					if (out_data.word_status !== e.word_status)
						report_mismatch($sformatf("word_status %b, want %b",
							out_data.word_status, e.word_status));
					if (out_data.last !== e.last)
						report_mismatch($sformatf("last %b, want %b", out_data.last, e.last));
					words_checked++;
					if (e.word_status == STATUS_CRC_ERR)
						crc_errs_seen++;
					if (e.last)
						finals_seen++;
				end
			end
			if (stall_left == 0 && !quiet && $urandom_range(0, 7) == 0)
				stall_left = $urandom_range(1, 15);
			if (stall_left > 0)
				stall_left--;
			out_stall <= rx_hold || (stall_left > 0);
		end
	end

	// one long receiver hold-off so the word queue fills and the input stalls
	always @(posedge clk) begin
		if (arst_n && !hold_done && words_accepted >= HOLD_AFTER) begin
			if (hold_count < HOLD_CYCLES) begin
				rx_hold <= 1'b1;
				hold_count++;
			end else begin
				rx_hold <= 1'b0;
				hold_done = 1'b1;
			end
		end
	end

	// bound the run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		int plan[13];
		logic [7:0] c;
		plan = '{1, 0, 15, 10, 9, 2, 5, 7, 3, 8, 4, 6, 9};
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: stray byte while halted, data extremes, CRC error, restart
		// in mid-response, then leave the response open across a register write
		push_byte(8'hA5, 1'b0);
		push_triplet(8'h00, 8'h00, 1'b0, 1'b1);
		push_triplet(8'hFF, 8'hFF, 1'b0, 1'b0);
		c = crc8_step(crc8_step(CRC_INIT, 8'hBE), 8'hEF);
		push_byte(8'hBE, 1'b0);
		push_byte(8'hEF, 1'b0);
		push_byte(c ^ 8'h01, 1'b0);
		push_byte(8'h3C, 1'b0);
		push_byte(8'h12, 1'b1);
		push_byte(8'h34, 1'b0);
		push_triplet(8'hAB, 8'hCD, 1'b0, 1'b1);
		push_triplet(8'h80, 8'h01, 1'b0, 1'b0);
		drain();
		// two words already done, so the next word closes the response
		write_words(4'd1);
		push_triplet(8'h7F, 8'hFE, 1'b0, 1'b0);
		push_byte(8'hFF, 1'b0);
		drain();

		// random phases over register settings, no idling near the end
		for (int p = 0; p < 13; p++) begin
			write_words(4'(plan[p]));
			quiet = (p >= 11);
			fill_phase(PHASE_BYTES);
			drain();
		end

		$display("Sent %0d bytes over %0d register settings; checked %0d words", words_queued,
			settings_used, words_checked);
		$display("(%0d with CRC errors, %0d closing a response)", crc_errs_seen, finals_seen);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
